// File: hdl/port_power_average_with_step_bypass_core_assert.svh
// Assertion macros for the port power averaging core.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef PORT_POWER_AVERAGE_WITH_STEP_BYPASS_CORE_ASSERT_SVH
`define PORT_POWER_AVERAGE_WITH_STEP_BYPASS_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define PPWR_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ppwr_avg: same-cycle check failed");

`define PPWR_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ppwr_avg: next-cycle check failed");

`else

`define PPWR_ASSERT_IMP(lbl, pre, post)

`define PPWR_ASSERT_NXT(lbl, pre, post)

`endif

`endif

// File: hdl/ppwr_avg_pkg.sv
package ppwr_avg_pkg;

    localparam int PORTS    = 3;
    localparam int WINDOW   = 5;
    localparam int PORT_W   = 2;
    localparam int POWER_W  = 8;
    localparam int DIGIT_W  = 4;
    localparam int THR_W    = 8;

    localparam int PORT_IDX_W = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int POS_W      = $clog2(WINDOW);
    localparam int SUM_W      = $clog2(((1 << POWER_W) - 1) * WINDOW + 1);

    // The mean divides by WINDOW through a reciprocal that is exact over the
    // whole range of a rounded window sum.
    localparam int MEAN_SHIFT = SUM_W + $clog2(WINDOW) + 1;
    localparam int MEAN_MULT  = ((1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W     = SUM_W + MEAN_SHIFT + 1;

    localparam logic [THR_W-1:0]   JUMP_RESET  = THR_W'(10);
    localparam logic [DIGIT_W-1:0] DIGIT_BLANK = DIGIT_W'(10);

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_IN   = 2'd1,
        ST_OUT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [PORT_IDX_W-1:0] port;
        status_t               status;
        logic [POWER_W-1:0]    power;
    } sample_t;

    typedef struct packed {
        logic [PORT_IDX_W-1:0] port;
        status_t               status;
        logic [POWER_W-1:0]    shown;
    } filt_res_t;

    function automatic logic [POWER_W-1:0] mean_of(input logic [SUM_W-1:0] s);
        logic [SUM_W:0]    rounded;
        logic [PROD_W-1:0] prod;
        rounded = {1'b0, s} + (SUM_W + 1)'(WINDOW / 2);
        prod    = PROD_W'(rounded) * PROD_W'(MEAN_MULT);
        return prod[MEAN_SHIFT +: POWER_W];
    endfunction

endpackage

// File: hdl/ppwr_avg_sample_if.sv
interface ppwr_avg_sample_if
    import ppwr_avg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PORT_W-1:0]  port;
    logic [1:0]         raw_status;
    logic [POWER_W-1:0] raw_power;

    modport source (output valid, output port, output raw_status, output raw_power,
                    input ready);
    modport sink   (input valid, input port, input raw_status, input raw_power,
                    output ready);
endinterface

// File: hdl/ppwr_avg_result_if.sv
interface ppwr_avg_result_if
    import ppwr_avg_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PORT_W-1:0]  port_out;
    logic [1:0]         shown_status;
    logic [POWER_W-1:0] shown_power;
    logic [DIGIT_W-1:0] digit_hundreds;
    logic [DIGIT_W-1:0] digit_tens;
    logic [DIGIT_W-1:0] digit_ones;

    modport source (output valid, output port_out, output shown_status,
                    output shown_power, output digit_hundreds, output digit_tens,
                    output digit_ones, input ready);
    modport sink   (input valid, input port_out, input shown_status,
                    input shown_power, input digit_hundreds, input digit_tens,
                    input digit_ones, output ready);
endinterface

// File: hdl/ppwr_avg_filter.sv
module ppwr_avg_filter
    import ppwr_avg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [THR_W-1:0] threshold,
    input  logic             update,
    input  sample_t          item,
    output filt_res_t        res
);

    logic [POWER_W-1:0] win_reg  [PORTS][WINDOW];
    logic [SUM_W-1:0]   sum_reg  [PORTS];
    logic [POS_W-1:0]   pos_reg  [PORTS];
    status_t            prev_reg [PORTS];

    logic [SUM_W-1:0]   sum_cur;
    logic [POS_W-1:0]   pos_cur;
    logic [POS_W-1:0]   pos_next;
    logic [POWER_W-1:0] oldest;
    logic [POWER_W-1:0] mean_cur;
    logic [POWER_W-1:0] diff;
    logic               refill;
    logic [SUM_W-1:0]   sum_push;
    logic [SUM_W-1:0]   sum_fill;
    logic [SUM_W-1:0]   sum_next;

    always_comb
    begin
        sum_cur  = sum_reg[item.port];
        pos_cur  = pos_reg[item.port];
        oldest   = win_reg[item.port][pos_cur];
        mean_cur = mean_of(sum_cur);
        diff     = (item.power > mean_cur) ? item.power - mean_cur : mean_cur - item.power;
        refill   = (item.status != prev_reg[item.port]) || (diff >= threshold);
        pos_next = (int'(pos_cur) == WINDOW - 1) ? '0 : pos_cur + POS_W'(1);
        sum_push = sum_cur - SUM_W'(oldest) + SUM_W'(item.power);
        sum_fill = SUM_W'(item.power) * SUM_W'(WINDOW);
        sum_next = refill ? sum_fill : sum_push;
    end

    // A refilled window holds WINDOW copies of the sample, so its mean is the sample.
    always_comb
    begin
        res.port   = item.port;
        res.status = item.status;
        if (item.status == ST_IDLE)
        begin
            res.shown = '0;
        end
        else if (refill)
        begin
            res.shown = item.power;
        end
        else
        begin
            res.shown = mean_of(sum_push);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORTS; p++)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    win_reg[p][k] <= '0;
                end
                sum_reg[p]  <= '0;
                pos_reg[p]  <= '0;
                prev_reg[p] <= ST_IDLE;
            end
        end
        else if (update)
        begin
            prev_reg[item.port] <= item.status;
            sum_reg[item.port]  <= sum_next;
            if (refill)
            begin
                for (int k = 0; k < WINDOW; k++)
                begin
                    win_reg[item.port][k] <= item.power;
                end
                pos_reg[item.port] <= '0;
            end
            else
            begin
                win_reg[item.port][pos_cur] <= item.power;
                pos_reg[item.port]          <= pos_next;
            end
        end
    end

endmodule

// File: hdl/ppwr_avg_out.sv
module ppwr_avg_out
    import ppwr_avg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  filt_res_t  in_res,
    ppwr_avg_result_if.source result
);

    // tens = (rem * 205) >> 11 is exact for every remainder below 100.
    localparam int TENS_RECIP = 205;
    localparam int TENS_SHIFT = 11;

    logic               valid_reg;
    logic [PORT_W-1:0]  port_reg;
    logic [1:0]         status_reg;
    logic [POWER_W-1:0] power_reg;
    logic [DIGIT_W-1:0] hund_reg;
    logic [DIGIT_W-1:0] tens_reg;
    logic [DIGIT_W-1:0] ones_reg;

    logic [1:0]         hund;
    logic [POWER_W-1:0] hund_sub;
    logic [6:0]         rem;
    logic [14:0]        tens_prod;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
    logic [DIGIT_W-1:0] hund_next;
    logic [DIGIT_W-1:0] tens_next;

    always_comb
    begin
        if (in_res.shown >= POWER_W'(200))
        begin
            hund     = 2'd2;
            hund_sub = POWER_W'(200);
        end
        else if (in_res.shown >= POWER_W'(100))
        begin
            hund     = 2'd1;
            hund_sub = POWER_W'(100);
        end
        else
        begin
            hund     = 2'd0;
            hund_sub = '0;
        end
        rem       = 7'(in_res.shown - hund_sub);
        tens_prod = 15'(rem) * 15'(TENS_RECIP);
        tens      = tens_prod[TENS_SHIFT +: DIGIT_W];
        ones      = DIGIT_W'(rem - 7'(tens) * 7'd10);
        hund_next = (in_res.shown >= POWER_W'(100)) ? DIGIT_W'(hund) : DIGIT_BLANK;
        tens_next = (in_res.shown >= POWER_W'(10)) ? tens : DIGIT_BLANK;
    end

    assign in_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            port_reg   <= PORT_W'(in_res.port);
            status_reg <= in_res.status;
            power_reg  <= in_res.shown;
            hund_reg   <= hund_next;
            tens_reg   <= tens_next;
            ones_reg   <= ones;
        end
    end

    assign result.valid          = valid_reg;
    assign result.port_out       = port_reg;
    assign result.shown_status   = status_reg;
    assign result.shown_power    = power_reg;
    assign result.digit_hundreds = hund_reg;
    assign result.digit_tens     = tens_reg;
    assign result.digit_ones     = ones_reg;

endmodule

// File: hdl/port_power_average_with_step_bypass_core.sv
// Per-port power smoothing for a display. Every sample transaction names a
// port, a raw status and a power in watts; each port keeps a running window
// of its last five samples, and a status change or a step away from the
// window mean by at least the jump threshold refills the window at once.
// Each sample gives exactly one result transaction with the sanitized status,
// the rounded mean (0 while idle) and three decimal digit codes, where 10 is
// a blank leading digit. The core is a three-stage pipeline (input register,
// window update, digit/output register): a sample taken into the input register
// passes through the window update register and then the digit/output register,
// and one sample is taken every cycle while the output side keeps up, including
// back-to-back samples for the same port.
// All window state is in flip-flops and is ready right after reset; the jump
// threshold resets to 10 and should be written only while the core is empty.
`include "port_power_average_with_step_bypass_core_assert.svh"

module port_power_average_with_step_bypass_core
    import ppwr_avg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [THR_W-1:0]   cfg_wdata,
    ppwr_avg_sample_if.sink    sample,
    ppwr_avg_result_if.source  result
);

    logic [THR_W-1:0] threshold_reg;

    logic      a_valid_reg;
    sample_t   a_item_reg;
    logic      a_ready;
    sample_t   in_item;

    logic      b_valid_reg;
    filt_res_t b_res_reg;
    logic      b_ready;

    logic      c_ready;
    filt_res_t filt_res;
    logic      update;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= JUMP_RESET;
        end
        else if (cfg_we)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    // Out-of-range ports fold onto the last port; an invalid status reads as idle.
    always_comb
    begin
        if (int'(sample.port) >= PORTS)
        begin
            in_item.port = PORT_IDX_W'(PORTS - 1);
        end
        else
        begin
            in_item.port = PORT_IDX_W'(sample.port);
        end
        case (sample.raw_status)
            ST_IN:   in_item.status = ST_IN;
            ST_OUT:  in_item.status = ST_OUT;
            default: in_item.status = ST_IDLE;
        endcase
        in_item.power = (in_item.status == ST_IDLE) ? '0 : sample.raw_power;
    end

    assign b_ready      = !b_valid_reg || c_ready;
    assign a_ready      = !a_valid_reg || b_ready;
    assign sample.ready = a_ready;
    assign update       = a_valid_reg && b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= sample.valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && sample.valid)
        begin
            a_item_reg <= in_item;
        end
        if (update)
        begin
            b_res_reg <= filt_res;
        end
    end

    ppwr_avg_filter u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .update    (update),
        .item      (a_item_reg),
        .res       (filt_res)
    );

    ppwr_avg_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (b_valid_reg),
        .in_ready (c_ready),
        .in_res   (b_res_reg),
        .result   (result)
    );

    `PPWR_ASSERT_IMP(idle_shows_zero, b_valid_reg && b_res_reg.status == ST_IDLE, b_res_reg.shown == '0)
    `PPWR_ASSERT_NXT(mid_holds_on_stall, b_valid_reg && !c_ready, b_valid_reg && $stable(b_res_reg))
    `PPWR_ASSERT_IMP(ready_when_out_empty, !result.valid, sample.ready)
    `PPWR_ASSERT_NXT(update_reaches_mid, update, b_valid_reg)

endmodule

// File: tb/port_power_average_with_step_bypass_core_tb.sv
module port_power_average_with_step_bypass_core_tb
    import ppwr_avg_pkg::*;
();

    localparam logic [1:0] RAW_ST_INVALID = 2'd3;

    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic [1:0]         status;
        logic [POWER_W-1:0] power;
    } port_sample_t;

    typedef struct packed {
        logic [PORT_W-1:0]  port;
        logic [1:0]         status;
        logic [POWER_W-1:0] power;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } shown_reading_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [THR_W-1:0] cfg_wdata;

    ppwr_avg_sample_if sample_bus ();
    ppwr_avg_result_if result_bus ();

    port_power_average_with_step_bypass_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (sample_bus),
        .result    (result_bus)
    );

    always #2 clk = ~clk;

    // Filter state as the testbench sees it.
    logic [POWER_W-1:0] window_watts [PORTS][WINDOW];
    int unsigned        ring_slot [PORTS];
    status_t            held_status [PORTS];
    logic [THR_W-1:0]   jump_level;

    port_sample_t   samples_pending [$];
    shown_reading_t readings_due [$];

    int src_gap_max = 15;
    int snk_stall_max = 15;
    int gap_left = 0;
    int stall_left = 0;
    logic sink_hold = 1'b0;

    int samples_taken = 0;
    int readings_checked = 0;
    int mismatch_count = 0;
    int thresholds_set = 1;

    int gen_level [4];
    logic [1:0] gen_status [4];

    function automatic logic [POWER_W-1:0] window_avg(input int unsigned p);
        int unsigned total;
        total = 0;
        for (int k = 0; k < WINDOW; k++)
            total += window_watts[p][k];
        return POWER_W'((total + WINDOW / 2) / WINDOW);
    endfunction

    function automatic shown_reading_t smooth_sample(input port_sample_t s);
        int unsigned p;
        status_t st;
        logic [POWER_W-1:0] pw;
        logic [POWER_W-1:0] avg;
        logic [POWER_W-1:0] step;
        logic [POWER_W-1:0] shown;
        shown_reading_t r;
        p = (s.port >= PORTS) ? PORTS - 1 : s.port;
        st = (s.status > ST_OUT) ? ST_IDLE : status_t'(s.status);
        pw = (st == ST_IDLE) ? '0 : s.power;
        avg = window_avg(p);
        step = (pw > avg) ? pw - avg : avg - pw;
        // A status change or a large step throws the old history away.
        if (st != held_status[p] || step >= jump_level) begin
            for (int k = 0; k < WINDOW; k++)
                window_watts[p][k] = pw;
            ring_slot[p] = 0;
        end
        else begin
            window_watts[p][ring_slot[p]] = pw;
            ring_slot[p] = (ring_slot[p] + 1 >= WINDOW) ? 0 : ring_slot[p] + 1;
        end
        held_status[p] = st;
        shown = (st == ST_IDLE) ? '0 : window_avg(p);
        r.port = PORT_W'(p);
        r.status = st;
        r.power = shown;
        r.hundreds = (shown >= 100) ? DIGIT_W'(shown / 100) : DIGIT_BLANK;
        r.tens = (shown >= 10) ? DIGIT_W'((shown / 10) % 10) : DIGIT_BLANK;
        r.ones = DIGIT_W'(shown % 10);
        return r;
    endfunction

    // Sample driver: offers queued samples, with a random gap after each one.
    always @(posedge clk or negedge rst_n)
    begin : drive_samples
        logic offer_next;
        port_sample_t next_item;
        if (!rst_n)
        begin
            sample_bus.valid <= 1'b0;
            sample_bus.port <= '0;
            sample_bus.raw_status <= '0;
            sample_bus.raw_power <= '0;
        end
        else
        begin
            offer_next = sample_bus.valid;
            if (sample_bus.valid && sample_bus.ready)
            begin
                next_item.port = sample_bus.port;
                next_item.status = sample_bus.raw_status;
                next_item.power = sample_bus.raw_power;
                readings_due.push_back(smooth_sample(next_item));
                samples_taken++;
                offer_next = 1'b0;
                gap_left = $urandom_range(0, src_gap_max);
            end
            if (!offer_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (samples_pending.size() != 0)
                begin
                    next_item = samples_pending.pop_front();
                    offer_next = 1'b1;
                    sample_bus.port <= next_item.port;
                    sample_bus.raw_status <= next_item.status;
                    sample_bus.raw_power <= next_item.power;
                end
            end
            sample_bus.valid <= offer_next;
        end
    end

    // Result monitor: checks every result transaction and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin : watch_readings
        shown_reading_t got;
        shown_reading_t want;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got.port = result_bus.port_out;
                got.status = result_bus.shown_status;
                got.power = result_bus.shown_power;
                got.hundreds = result_bus.digit_hundreds;
                got.tens = result_bus.digit_tens;
                got.ones = result_bus.digit_ones;
                if (readings_due.size() == 0)
                begin
                    $display("%0t: unexpected result: port %0d status %0d power %0d digits %0d %0d %0d",
                             $time, got.port, got.status, got.power, got.hundreds, got.tens,
                             got.ones);
                    mismatch_count++;
                end
                else
                begin
                    want = readings_due.pop_front();
                    readings_checked++;
                    if (got !== want)
                    begin
                        $display("%0t: expected port %0d status %0d power %0d digits %0d %0d %0d",
                                 $time, want.port, want.status, want.power, want.hundreds,
                                 want.tens, want.ones);
                        $display("%0t: actual   port %0d status %0d power %0d digits %0d %0d %0d",
                                 $time, got.port, got.status, got.power, got.hundreds,
                                 got.tens, got.ones);
                        mismatch_count++;
                    end
                end
                stall_left = $urandom_range(0, snk_stall_max);
            end
            else if (stall_left > 0)
                stall_left--;
            result_bus.ready <= !sink_hold && stall_left == 0;
        end
    end

    task automatic add_sample(input logic [PORT_W-1:0] port, input logic [1:0] status,
                              input logic [POWER_W-1:0] power);
        port_sample_t s;
        s.port = port;
        s.status = status;
        s.power = power;
        samples_pending.push_back(s);
    endtask

    // Mostly steady per-port traces with noise, plus occasional steps, status
    // changes and completely random samples.
    task automatic add_random_samples(input int count);
        int q;
        int roll;
        int lvl;
        @(negedge clk);
        for (int i = 0; i < count; i++)
        begin
            q = $urandom_range(0, 3);
            roll = $urandom_range(0, 99);
            if (roll < 5)
                add_sample(PORT_W'(q), 2'($urandom_range(0, 3)),
                           POWER_W'($urandom_range(0, 255)));
            else
            begin
                if (roll < 13)
                    gen_status[q] = 2'($urandom_range(0, 3));
                else if (roll < 25)
                    gen_level[q] = $urandom_range(0, 255);
                lvl = gen_level[q] + int'($urandom_range(0, 24)) - 12;
                if (lvl < 0)
                    lvl = 0;
                if (lvl > 255)
                    lvl = 255;
                add_sample(PORT_W'(q), gen_status[q], POWER_W'(lvl));
            end
        end
    endtask

    task automatic settle_pipeline();
        int guard;
        guard = 0;
        while ((samples_pending.size() != 0 || sample_bus.valid || readings_due.size() != 0)
               && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic begin_phase(input logic [THR_W-1:0] level, input int gap_max,
                               input int stall_max);
        settle_pipeline();
        @(posedge clk);
        cfg_wdata <= level;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        jump_level = level;
        thresholds_set++;
        src_gap_max = gap_max;
        snk_stall_max = stall_max;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        for (int p = 0; p < PORTS; p++)
        begin
            for (int k = 0; k < WINDOW; k++)
                window_watts[p][k] = '0;
            ring_slot[p] = 0;
            held_status[p] = ST_IDLE;
        end
        jump_level = JUMP_RESET;
        for (int q = 0; q < 4; q++)
        begin
            gen_status[q] = (q == 1) ? ST_OUT : ST_IN;
            gen_level[q] = $urandom_range(0, 255);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed samples at the reset threshold of 10.
        @(negedge clk);
        add_sample(0, ST_IN, 255);
        add_sample(0, ST_IN, 250);
        add_sample(0, ST_IN, 0);
        add_sample(0, ST_IN, 9);
        add_sample(0, ST_IN, 12);
        add_sample(0, ST_OUT, 12);
        add_sample(0, ST_OUT, 128);
        add_sample(0, ST_OUT, 127);
        add_sample(0, ST_OUT, 85);
        add_sample(1, ST_OUT, 99);
        add_sample(1, ST_OUT, 100);
        add_sample(1, ST_OUT, 109);
        add_sample(1, RAW_ST_INVALID, 200);
        add_sample(1, ST_IDLE, 77);
        add_sample(1, ST_IDLE, 0);
        add_sample(1, ST_IN, 1);
        add_sample(1, ST_IN, 10);
        add_sample(2, ST_IN, 5);
        add_sample(3, ST_IN, 6);
        add_sample(3, ST_OUT, 170);
        add_sample(3, RAW_ST_INVALID, 255);
        add_sample(2, ST_IDLE, 1);
        add_random_samples(60);

        begin_phase(8'd255, 0, 0);
        add_random_samples(70);
        begin_phase(8'd1, 15, 0);
        add_random_samples(70);
        begin_phase(8'd0, 0, 15);
        add_random_samples(60);
        begin_phase(THR_W'($urandom_range(2, 254)), 15, 15);
        add_random_samples(70);
        begin_phase(THR_W'($urandom_range(2, 254)), 0, 0);
        add_random_samples(70);

        // Hold the output off long enough for the pipeline to back up into
        // the sample input while the driver keeps offering.
        begin_phase(8'd40, 0, 0);
        @(negedge clk);
        sink_hold = 1'b1;
        add_random_samples(40);
        repeat (80) @(negedge clk);
        sink_hold = 1'b0;
        snk_stall_max = 15;
        add_random_samples(40);

        settle_pipeline();
        if (readings_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, readings_due.size());
            mismatch_count += readings_due.size();
        end
        $display("Sent %0d samples over %0d jump thresholds, including 0, 1 and 255,",
                 samples_taken, thresholds_set);
        $display("with random gaps and one long output stall; %0d readings checked.",
                 readings_checked);
        if (mismatch_count == 0)
            $display("port_power_average_with_step_bypass_core: match");
        else
            $display("port_power_average_with_step_bypass_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run timed out.");
        $display("port_power_average_with_step_bypass_core: mismatch");
        $finish;
    end

endmodule
